[rtl/wflt_pkg.sv]
// Shared types, codes and frame helpers for the anemometer frame transmitter.
package wflt_pkg;

    localparam int SPEED_W   = 14;
    localparam int DIR_W     = 4;
    localparam int UNITS_W   = 12;
    localparam int NUM_W     = 28;
    localparam int FRAME_W   = 41;

    // Speed conversion: units = floor((s * 12573 + 22500) / 45000), saturated.
    // The divide by 45000 is a shift by 3 and a reciprocal multiply for 5625.
    localparam logic [13:0] SPEED_MUL   = 14'd12573;
    localparam logic [14:0] SPEED_ROUND = 15'd22500;
    localparam logic [25:0] RECIP_5625  = 26'd48867184;
    localparam int          RECIP_SHIFT = 38;
    localparam logic [UNITS_W-1:0] UNITS_MAX = 12'hFFF;

    typedef enum logic [1:0] {
        CTL_DISABLED = 2'd0,
        CTL_START    = 2'd1,
        CTL_SAMPLING = 2'd2,
        CTL_SENDING  = 2'd3
    } ctl_state_t;

    typedef enum logic [2:0] {
        EV_LEVEL        = 3'd0,
        EV_START_SAMPLE = 3'd1,
        EV_ABORT        = 3'd2,
        EV_FRAME_START  = 3'd3,
        EV_FRAME_END    = 3'd4,
        EV_SAMPLE_END   = 3'd5,
        EV_BIT          = 3'd6
    } event_t;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_FRAME = 1'b1
    } back_state_t;

    // One job from the front to the back: a single event or a whole frame.
    typedef struct packed {
        logic                is_frame;
        logic                line;
        event_t              ev;
        logic                en_high;
        logic [UNITS_W-1:0]  speed;
        logic [DIR_W-1:0]    dir;
    } cmd_t;

    // Frame bits in send order, bit 0 goes out first.
    function automatic logic [FRAME_W-1:0] frame_bits(input logic [UNITS_W-1:0] sp,
                                                      input logic [DIR_W-1:0] dr);
        logic [3:0] sum;
        sum = dr + sp[3:0] + sp[7:4] + sp[11:8];
        return {~sp, ~dr, sum, sp, dr, 5'b00100};
    endfunction

endpackage

[rtl/wflt_cmd_fifo.sv]
// Two-entry job queue between the front and the back.
module wflt_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wflt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          cmd_valid,
    output wflt_pkg::cmd_t cmd
);
    import wflt_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/wflt_front.sv]
// Front part: accepts items, runs the enable-line control and issues jobs.
module wflt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          kind,
    input  logic                          enable_high,
    input  logic [wflt_pkg::SPEED_W-1:0]  wind_speed_mph,
    input  logic [wflt_pkg::DIR_W-1:0]    wind_direction,
    input  logic                          q_full,
    output logic                          push,
    output wflt_pkg::cmd_t                push_cmd
);
    import wflt_pkg::*;

    ctl_state_t           state_reg, state_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [DIR_W-1:0]     dir_reg, dir_next;
    logic                 acc;
    logic                 tick;
    logic                 done;
    logic [NUM_W-1:0]     num_calc;
    logic [50:0]          recip_prod;
    logic [12:0]          quot;
    logic [UNITS_W-1:0]   units;

    assign s_tready = ~q_full;
    assign acc      = s_tvalid & s_tready;
    assign tick     = acc & ~kind;
    assign done     = acc & kind;

    // Scaled numerator of the speed conversion, kept until the sending tick.
    assign num_calc = NUM_W'(wind_speed_mph) * NUM_W'(SPEED_MUL) + NUM_W'(SPEED_ROUND);

    // Quotient by 45000: drop three bits, then the reciprocal of 5625.
    assign recip_prod = num_reg[NUM_W-1:3] * RECIP_5625;
    assign quot       = recip_prod[50:RECIP_SHIFT];
    assign units      = quot[12] ? UNITS_MAX : quot[UNITS_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        if (done)
        begin
            if (state_reg == CTL_SAMPLING)
            begin
                state_next = CTL_SENDING;
            end
        end
        else if (tick)
        begin
            unique case (state_reg)
                CTL_DISABLED: if (!enable_high) state_next = CTL_START;
                CTL_START:    state_next = CTL_SAMPLING;
                CTL_SAMPLING: if (enable_high) state_next = CTL_DISABLED;
                CTL_SENDING:  state_next = enable_high ? CTL_DISABLED : CTL_START;
                default:      state_next = CTL_DISABLED;
            endcase
        end
    end

    always_comb
    begin
        push              = 1'b0;
        push_cmd.is_frame = 1'b0;
        push_cmd.line     = 1'b0;
        push_cmd.ev       = EV_LEVEL;
        push_cmd.en_high  = enable_high;
        push_cmd.speed    = units;
        push_cmd.dir      = dir_reg;
        num_next          = num_reg;
        dir_next          = dir_reg;
        if (done && state_reg == CTL_SAMPLING)
        begin
            num_next = num_calc;
            dir_next = wind_direction;
        end
        if (tick)
        begin
            unique case (state_reg)
                CTL_DISABLED:
                begin
                    push = ~enable_high;
                end
                CTL_START:
                begin
                    push        = 1'b1;
                    push_cmd.ev = EV_START_SAMPLE;
                end
                CTL_SAMPLING:
                begin
                    push          = enable_high;
                    push_cmd.ev   = EV_ABORT;
                    push_cmd.line = 1'b1;
                end
                CTL_SENDING:
                begin
                    push              = 1'b1;
                    push_cmd.is_frame = 1'b1;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        dir_reg <= dir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_DISABLED;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/wflt_back.sv]
// Back part: turns jobs into result items, one per cycle while the output is free, through an output register.
module wflt_back #(
    parameter int TRAILER_LOW_BITS = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  wflt_pkg::cmd_t cmd,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic           line_level,
    output logic [2:0]     event_code,
    output logic           last
);
    import wflt_pkg::*;

    // Frame start, frame bits, trailer bits, frame end, sample end.
    localparam int NRES     = FRAME_W + TRAILER_LOW_BITS + 3;
    localparam int CW       = $clog2(NRES);
    localparam logic [CW-1:0] END_IDX  = CW'(NRES - 2);
    localparam logic [CW-1:0] LAST_IDX = CW'(NRES - 1);

    back_state_t        state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [FRAME_W-1:0] shift_reg, shift_next;
    logic               en_reg, en_next;
    logic               valid_reg, valid_next;
    logic               line_reg, line_next;
    event_t             ev_reg, ev_next;
    logic               last_reg, last_next;
    logic               out_free;
    logic               load;

    assign out_free   = ~valid_reg | m_tready;
    assign m_tvalid   = valid_reg;
    assign line_level = line_reg;
    assign event_code = ev_reg;
    assign last       = last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free && cmd.is_frame)
                begin
                    state_next = BK_FRAME;
                end
            end
            BK_FRAME:
            begin
                if (out_free && cnt_reg == LAST_IDX)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        load       = 1'b0;
        line_next  = line_reg;
        ev_next    = ev_reg;
        last_next  = last_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        en_next    = en_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    pop  = 1'b1;
                    load = 1'b1;
                    if (cmd.is_frame)
                    begin
                        line_next  = 1'b0;
                        ev_next    = EV_FRAME_START;
                        last_next  = 1'b0;
                        shift_next = frame_bits(cmd.speed, cmd.dir);
                        cnt_next   = CW'(1);
                        en_next    = cmd.en_high;
                    end
                    else
                    begin
                        line_next = cmd.line;
                        ev_next   = cmd.ev;
                        last_next = 1'b1;
                    end
                end
            end
            BK_FRAME:
            begin
                if (out_free)
                begin
                    load     = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == LAST_IDX)
                    begin
                        line_next = en_reg;
                        ev_next   = EV_SAMPLE_END;
                        last_next = 1'b1;
                    end
                    else if (cnt_reg == END_IDX)
                    begin
                        // The line keeps the level of the last bit sent.
                        ev_next = EV_FRAME_END;
                    end
                    else
                    begin
                        // Zeros shift in behind the frame and form the trailer.
                        line_next  = ~shift_reg[0];
                        ev_next    = EV_BIT;
                        shift_next = shift_reg >> 1;
                    end
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        en_reg    <= en_next;
        ev_reg    <= ev_next;
        last_reg  <= last_next;
        cnt_reg   <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
            line_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            line_reg  <= line_next;
        end
    end

endmodule

[rtl/wind_frame_line_transmitter_top.sv]
// Anemometer frame transmitter: front control, job queue and serializing back end.
// A result item goes through the job queue and then the output register of the back end.
// Items are taken one per cycle while the queue is not full; a sending tick gives 44 +
// TRAILER_LOW_BITS items, one per cycle from that single register while m_tready is high.
// A two-job queue lets the front keep taking items while a frame is sent.
// Reset (rst_n, asynchronous, active low): control disabled, queue empty, line high.
module wind_frame_line_transmitter_top #(
    parameter int TRAILER_LOW_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // enable_high, wind_speed_mph[13:0], wind_direction[3:0]
    input  logic [0:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // line_level
    output logic [2:0]  m_tuser,   // event_code
    output logic        m_tlast
);
    import wflt_pkg::*;

    logic  q_full;
    logic  push;
    cmd_t  push_cmd;
    logic  pop;
    logic  cmd_valid;
    cmd_t  cmd;
    logic  line_level;

    assign m_tdata = {7'd0, line_level};

    wflt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .kind           (s_tuser[0]),
        .enable_high    (s_tdata[0]),
        .wind_speed_mph (s_tdata[14:1]),
        .wind_direction (s_tdata[18:15]),
        .q_full         (q_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    wflt_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    wflt_back #(
        .TRAILER_LOW_BITS (TRAILER_LOW_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .line_level (line_level),
        .event_code (m_tuser),
        .last       (m_tlast)
    );

endmodule

[tb/sv/tb_wind_frame_line_transmitter_top.sv]
// Testbench for the anemometer frame transmitter: stream stimulus, predicted line events, checks.
module tb_wind_frame_line_transmitter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wflt_pkg::*;

    localparam int TRAILER_BITS = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 400;
    localparam bit KIND_TICK    = 1'b0;
    localparam bit KIND_SAMPLE  = 1'b1;

    typedef struct packed {
        logic   line;
        event_t ev;
        logic   last;
    } line_event_t;

    // Tracks the transmitter state and holds the line events still to come.
    class line_event_board;
        ctl_state_t          ctl;
        logic [UNITS_W-1:0]  held_units;
        logic [DIR_W-1:0]    held_dir;
        logic                line;
        line_event_t         pending_events[$];
        int                  errors;

        function new();
            ctl = CTL_DISABLED;
            held_units = '0;
            held_dir = '0;
            line = 1'b1;
            errors = 0;
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void post(event_t ev);
            line_event_t e;
            e.line = line;
            e.ev = ev;
            e.last = 1'b0;
            pending_events.push_back(e);
        endfunction

        function void shift_out(logic [11:0] value, int count);
            for (int i = 0; i < count; i++) begin
                line = ~value[i];
                post(EV_BIT);
            end
        endfunction

        // Speed in 1/16 mph to 0.1 m/s, rounded half up, saturated at the 12-bit limit.
        function logic [UNITS_W-1:0] to_tenths_ms(logic [SPEED_W-1:0] s);
            int unsigned u;
            u = (32'(s) * 32'd12573 + 32'd22500) / 32'd45000;
            return (u > 32'd4095) ? UNITS_MAX : u[UNITS_W-1:0];
        endfunction

        // Returns 1 when the item changed the state or caused line events.
        function bit take_item(bit kind, bit en_high, logic [SPEED_W-1:0] speed,
                               logic [DIR_W-1:0] dir);
            int                 before_cnt;
            ctl_state_t         old_ctl;
            logic [3:0]         sum;
            line_event_t        tail;
            before_cnt = pending_events.size();
            old_ctl = ctl;
            if (kind == KIND_SAMPLE) begin
                if (ctl == CTL_SAMPLING) begin
                    held_units = to_tenths_ms(speed);
                    held_dir = dir;
                    ctl = CTL_SENDING;
                    line = 1'b0;
                    return 1'b1;
                end
                return 1'b0;
            end
            case (ctl)
                CTL_DISABLED: begin
                    if (!en_high) begin
                        ctl = CTL_START;
                        line = 1'b0;
                        post(EV_LEVEL);
                    end
                end
                CTL_START: begin
                    ctl = CTL_SAMPLING;
                    line = 1'b0;
                    post(EV_START_SAMPLE);
                end
                CTL_SAMPLING: begin
                    if (en_high) begin
                        ctl = CTL_DISABLED;
                        line = 1'b1;
                        post(EV_ABORT);
                    end
                end
                default: begin
                    sum = held_dir + held_units[3:0] + held_units[7:4] + held_units[11:8];
                    line = 1'b0;
                    post(EV_FRAME_START);
                    shift_out(12'h004, 5);
                    shift_out({8'h00, held_dir}, 4);
                    shift_out(held_units, 12);
                    shift_out({8'h00, sum}, 4);
                    shift_out({8'h00, ~held_dir}, 4);
                    shift_out(~held_units, 12);
                    for (int t = 0; t < TRAILER_BITS; t++)
                        shift_out(12'h000, 1);
                    post(EV_FRAME_END);
                    if (en_high) begin
                        ctl = CTL_DISABLED;
                        line = 1'b1;
                    end else begin
                        ctl = CTL_START;
                        line = 1'b0;
                    end
                    post(EV_SAMPLE_END);
                end
            endcase
            if (pending_events.size() > before_cnt) begin
                tail = pending_events.pop_back();
                tail.last = 1'b1;
                pending_events.push_back(tail);
            end
            return (pending_events.size() > before_cnt) || (ctl != old_ctl);
        endfunction

        function void check_event(logic [7:0] tdata, logic [2:0] tuser, logic tlast);
            line_event_t e;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result line=%0d event=%0d last=%0d",
                         $time, tdata[0], tuser, tlast);
                errors++;
                return;
            end
            e = pending_events.pop_front();
            if (tdata !== {7'b0, e.line}) begin
                $display("%0t: line_level mismatch, expected %0d, actual %0d",
                         $time, {7'b0, e.line}, tdata);
                errors++;
            end
            if (tuser !== e.ev) begin
                $display("%0t: event_code mismatch, expected %0d, actual %0d",
                         $time, e.ev, tuser);
                errors++;
            end
            if (tlast !== e.last) begin
                $display("%0t: last mismatch, expected %0d, actual %0d",
                         $time, e.last, tlast);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    line_event_board board = new();
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;
    int  cycle_count = 0;
    int  random_cnt = 0;

    wind_frame_line_transmitter_top #(
        .TRAILER_LOW_BITS(TRAILER_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #1 clk = ~clk;

    // Offers one item, with random gaps before it, and records it once accepted.
    task automatic send_item(bit kind, bit en_high, logic [SPEED_W-1:0] speed,
                             logic [DIR_W-1:0] dir, output bit counted);
        while (!steady && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {5'b0, dir, speed, en_high};
        do
            @(posedge clk);
        while (!s_tready);
        counted = board.take_item(kind, en_high, speed, dir);
    endtask

    task automatic send(bit kind, bit en_high, logic [SPEED_W-1:0] speed,
                        logic [DIR_W-1:0] dir);
        bit counted;
        send_item(kind, en_high, speed, dir, counted);
    endtask

    // Picks the next item from the predicted state so that most runs reach a full frame.
    task automatic send_random();
        int  r;
        bit  counted;
        bit  en;
        logic [SPEED_W-1:0] speed;
        logic [DIR_W-1:0]   dir;
        r = $urandom_range(99);
        en = $urandom_range(1);
        speed = $urandom_range(16383);
        dir = $urandom_range(15);
        case (board.ctl)
            CTL_DISABLED: begin
                if (r < 85)
                    send_item(KIND_TICK, 1'b0, speed, dir, counted);
                else if (r < 93)
                    send_item(KIND_TICK, 1'b1, speed, dir, counted);
                else
                    send_item(KIND_SAMPLE, en, speed, dir, counted);
            end
            CTL_START: begin
                if (r < 90)
                    send_item(KIND_TICK, en, speed, dir, counted);
                else
                    send_item(KIND_SAMPLE, en, speed, dir, counted);
            end
            CTL_SAMPLING: begin
                if (r < 78)
                    send_item(KIND_SAMPLE, en, speed, dir, counted);
                else if (r < 90)
                    send_item(KIND_TICK, 1'b0, speed, dir, counted);
                else
                    send_item(KIND_TICK, 1'b1, speed, dir, counted);
            end
            default: begin
                if (r < 90)
                    send_item(KIND_TICK, $urandom_range(99) < 30, speed, dir, counted);
                else
                    send_item(KIND_SAMPLE, en, speed, dir, counted);
            end
        endcase
        if (counted)
            random_cnt++;
    endtask

    // Result side: the receiver stalls at random and once holds off for a long stretch.
    initial begin : sink_pacing
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 26);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            board.check_event(m_tdata, m_tuser, m_tlast);
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("wind_frame_line_transmitter_top test failed");
        $finish;
    end

    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ignored sample, disabled tick with enable high, then the enable goes low.
        send(KIND_SAMPLE, 1'b1, 14'h3FFF, 4'hF);
        send(KIND_TICK, 1'b1, 14'h0000, 4'h0);
        send(KIND_TICK, 1'b0, 14'h3FFF, 4'hF);
        send(KIND_SAMPLE, 1'b0, 14'd100, 4'd3);
        send(KIND_TICK, 1'b1, 14'h0000, 4'h0);
        // Sampling: a low tick does nothing, a high tick aborts.
        send(KIND_TICK, 1'b0, 14'h0000, 4'h0);
        send(KIND_TICK, 1'b1, 14'h0000, 4'h0);
        send(KIND_TICK, 1'b0, 14'h0000, 4'h0);
        send(KIND_TICK, 1'b0, 14'h0000, 4'h0);
        send(KIND_SAMPLE, 1'b1, 14'h0000, 4'h0);
        send(KIND_SAMPLE, 1'b0, 14'd5, 4'd5);
        send(KIND_TICK, 1'b0, 14'h0000, 4'h0);
        send(KIND_TICK, 1'b0, 14'h0000, 4'h0);
        // Largest speed saturates the converted value.
        send(KIND_SAMPLE, 1'b0, 14'h3FFF, 4'hF);
        send(KIND_TICK, 1'b1, 14'h3FFF, 4'hF);
        send(KIND_TICK, 1'b0, 14'h0000, 4'h0);
        send(KIND_TICK, 1'b1, 14'h0000, 4'h0);
        // Just at the top of the unsaturated range.
        send(KIND_SAMPLE, 1'b0, 14'd14655, 4'd10);
        send(KIND_TICK, 1'b0, 14'h0000, 4'h0);
        send(KIND_TICK, 1'b0, 14'h0000, 4'h0);
        send(KIND_SAMPLE, 1'b1, 14'd1, 4'd1);
        send(KIND_TICK, 1'b1, 14'h0000, 4'h0);

        hold_req = 1'b1;
        while (random_cnt < RANDOM_ITEMS) begin
            steady = (random_cnt >= 200) && (random_cnt < 320);
            send_random();
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("wind_frame_line_transmitter_top test passed");
        else
            $display("wind_frame_line_transmitter_top test failed");
        $finish;
    end

endmodule
